[rtl/core/hwh_pkg.sv]
// ---------------------------------------------------------------------------
// Hamming weight histogram package
// Shared constants, request codes and the queue entry type.
// ---------------------------------------------------------------------------
package hwh_pkg;

   localparam int OUTPUT_BYTES = 8;
   localparam int BYTE_BITS    = 8;
   localparam int DATA_W       = OUTPUT_BYTES * BYTE_BITS;
   localparam int NUM_CATS     = DATA_W + 1;
   localparam int CAT_W        = $clog2(NUM_CATS);
   localparam int COUNT_WIDTH  = 32;
   localparam int ACCUM_W      = 32;
   localparam int FIT_W        = 48;
   localparam int FRAC_W       = 16;
   localparam int SPARSE_W     = CAT_W + 2;

   localparam logic [1:0] REQ_SAMPLE  = 2'd0;
   localparam logic [1:0] REQ_FITNESS = 2'd1;
   localparam logic [1:0] REQ_END     = 2'd2;

   localparam logic [1:0] CSR_USED_BYTES = 2'd0;
   localparam logic [1:0] CSR_THRESHOLD  = 2'd1;
   localparam logic [1:0] CSR_CHECKED    = 2'd2;

   localparam logic [3:0]  USED_BYTES_RST = 4'd8;
   localparam logic [15:0] THRESHOLD_RST  = 16'd5;
   localparam logic [6:0]  CHECKED_RST    = 7'd65;

   typedef struct packed {
      logic [1:0]       req;
      logic [CAT_W-1:0] weight;
      logic             sel;
   } hwh_entry_type;

   // Byte count clamped to the width of the output word.
   function automatic logic [3:0] eff_bytes(input logic [3:0] used);
      logic [3:0] r;
      r = (used > 4'(OUTPUT_BYTES)) ? 4'(OUTPUT_BYTES) : used;
      return r;
   endfunction

endpackage

[rtl/core/hamming_weight_histogram_chi_square.sv]
// ---------------------------------------------------------------------------
// Hamming weight histogram with chi-square readout
// Two weight histograms, a chi-square fitness walk and a sparse count.
// ---------------------------------------------------------------------------
//  Port group   Direction  Transfer
//  req_*        in         start high while busy is low
//  rsp_*        out        rsp_valid high for one cycle, never stalled
//  csr_*        in         csr_write_enable high, no wait
//
//  In the engine a sample is a histogram read, then its write. A fitness
//  request walks every used category through the one-bit-per-cycle divider;
//  an end request walks the checked categories, at most the used ones. Reset
//  is synchronous and clears every histogram at once through per-entry valid
//  bits. busy rises when the two-entry queue fills.
// ---------------------------------------------------------------------------
module hamming_weight_histogram_chi_square (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic [1:0]                      req_type,
   input  logic [hwh_pkg::DATA_W-1:0]      req_output_bits,
   input  logic [7:0]                      req_reference_byte,
   output logic                            rsp_valid,
   output logic [hwh_pkg::CAT_W-1:0]       rsp_hamming_weight,
   output logic [hwh_pkg::FIT_W-1:0]       rsp_fitness_fixed,
   output logic [hwh_pkg::COUNT_WIDTH-1:0] rsp_total_zero,
   output logic [hwh_pkg::COUNT_WIDTH-1:0] rsp_total_one,
   output logic [hwh_pkg::ACCUM_W-1:0]     rsp_under_threshold_total,
   input  logic                            csr_write_enable,
   input  logic [1:0]                      csr_index,
   input  logic [15:0]                     csr_write_data
);
   import hwh_pkg::*;

   logic [3:0]    used_bytes_ff;
   logic [15:0]   threshold_ff;
   logic [6:0]    checked_ff;
   hwh_entry_type front_entry, q_head;
   logic          q_full, q_not_empty, q_pop, push;

   always_ff @(posedge clock) begin
      if (reset) begin
         used_bytes_ff <= USED_BYTES_RST;
         threshold_ff  <= THRESHOLD_RST;
         checked_ff    <= CHECKED_RST;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_USED_BYTES: used_bytes_ff <= csr_write_data[3:0];
            CSR_THRESHOLD:  threshold_ff  <= csr_write_data;
            CSR_CHECKED:    checked_ff    <= csr_write_data[6:0];
            default: ;
         endcase
      end
   end

   assign busy = q_full;
   assign push = start && !q_full;

   hwh_front u_front (
      .req_type          (req_type),
      .req_output_bits   (req_output_bits),
      .req_reference_byte(req_reference_byte),
      .used_bytes        (used_bytes_ff),
      .entry             (front_entry)
   );

   hwh_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_entry(front_entry),
      .pop       (q_pop),
      .full      (q_full),
      .not_empty (q_not_empty),
      .head      (q_head)
   );

   hwh_back u_back (
      .clock                    (clock),
      .reset                    (reset),
      .q_not_empty              (q_not_empty),
      .q_head                   (q_head),
      .q_pop                    (q_pop),
      .used_bytes               (used_bytes_ff),
      .sparse_limit             (threshold_ff),
      .checked_categories       (checked_ff),
      .rsp_valid                (rsp_valid),
      .rsp_hamming_weight       (rsp_hamming_weight),
      .rsp_fitness_fixed        (rsp_fitness_fixed),
      .rsp_total_zero           (rsp_total_zero),
      .rsp_total_one            (rsp_total_one),
      .rsp_under_threshold_total(rsp_under_threshold_total)
   );

endmodule

[rtl/core/hwh_ram.sv]
// ---------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ---------------------------------------------------------------------------
module hwh_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 65
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/core/hwh_front.sv]
// ---------------------------------------------------------------------------
// Histogram front end
// Classifies a request and computes the masked Hamming weight of a sample.
// ---------------------------------------------------------------------------
module hwh_front (
   input  logic [1:0]                   req_type,
   input  logic [hwh_pkg::DATA_W-1:0]   req_output_bits,
   input  logic [7:0]                   req_reference_byte,
   input  logic [3:0]                   used_bytes,
   output hwh_pkg::hwh_entry_type       entry
);
   import hwh_pkg::*;

   logic [3:0]       eff;
   logic [3:0]       byte_cnt [OUTPUT_BYTES];
   logic [CAT_W-1:0] weight;

   assign eff = eff_bytes(used_bytes);

   always_comb begin
      for (int j = 0; j < OUTPUT_BYTES; j++) begin
         byte_cnt[j] = '0;
         if (4'(j) < eff) begin
            for (int b = 0; b < BYTE_BITS; b++) begin
               byte_cnt[j] = byte_cnt[j] + 4'(req_output_bits[j*BYTE_BITS+b]);
            end
         end
      end
      weight = '0;
      for (int j = 0; j < OUTPUT_BYTES; j++) begin
         weight = weight + CAT_W'(byte_cnt[j]);
      end
   end

   always_comb begin
      entry.req    = req_type;
      entry.weight = (req_type == REQ_SAMPLE) ? weight : '0;
      entry.sel    = req_reference_byte[BYTE_BITS-1];
   end

endmodule

[rtl/core/hwh_queue.sv]
// ---------------------------------------------------------------------------
// Request queue
// Two-entry queue between the front end and the histogram engine.
// ---------------------------------------------------------------------------
module hwh_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  hwh_pkg::hwh_entry_type push_entry,
   input  logic                   pop,
   output logic                   full,
   output logic                   not_empty,
   output hwh_pkg::hwh_entry_type head
);
   import hwh_pkg::*;

   hwh_entry_type slot_ff [2];
   logic          wr_ptr_ff, wr_ptr_in;
   logic          rd_ptr_ff, rd_ptr_in;
   logic [1:0]    cnt_ff, cnt_in;

   assign full      = (cnt_ff == 2'd2);
   assign not_empty = (cnt_ff != 2'd0);
   assign head      = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? ~rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

[rtl/core/hwh_back.sv]
// ---------------------------------------------------------------------------
// Histogram engine
// Updates the histograms, walks them for the chi-square sum and for the
// end-of-epoch sparse count, and drives the result registers.
// ---------------------------------------------------------------------------
module hwh_back (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          q_not_empty,
   input  hwh_pkg::hwh_entry_type        q_head,
   output logic                          q_pop,
   input  logic [3:0]                    used_bytes,
   input  logic [15:0]                   sparse_limit,
   input  logic [6:0]                    checked_categories,
   output logic                          rsp_valid,
   output logic [hwh_pkg::CAT_W-1:0]     rsp_hamming_weight,
   output logic [hwh_pkg::FIT_W-1:0]     rsp_fitness_fixed,
   output logic [hwh_pkg::COUNT_WIDTH-1:0] rsp_total_zero,
   output logic [hwh_pkg::COUNT_WIDTH-1:0] rsp_total_one,
   output logic [hwh_pkg::ACCUM_W-1:0]   rsp_under_threshold_total
);
   import hwh_pkg::*;

   localparam logic [3:0] ST_IDLE = 4'd0;
   localparam logic [3:0] ST_SWR  = 4'd1;
   localparam logic [3:0] ST_RD   = 4'd2;
   localparam logic [3:0] ST_LOAD = 4'd3;
   localparam logic [3:0] ST_MUL  = 4'd4;
   localparam logic [3:0] ST_DIVI = 4'd5;
   localparam logic [3:0] ST_DIV  = 4'd6;
   localparam logic [3:0] ST_ACC  = 4'd7;
   localparam logic [3:0] ST_EFIN = 4'd8;

   localparam int DIV_STEPS = COUNT_WIDTH + FRAC_W;

   logic [3:0]             state_ff, state_in;
   logic                   is_fit_ff, is_fit_in;
   logic [CAT_W-1:0]       cat_ff, cat_in;
   logic [CAT_W-1:0]       weight_ff, weight_in;
   logic                   sel_ff, sel_in;
   logic [NUM_CATS-1:0]    vz_ff, vz_in;
   logic [NUM_CATS-1:0]    vo_ff, vo_in;
   logic                   vz_rd_ff, vo_rd_ff;
   logic [COUNT_WIDTH-1:0] cnt_zero_ff, cnt_zero_in;
   logic [COUNT_WIDTH-1:0] cnt_one_ff, cnt_one_in;
   logic [ACCUM_W-1:0]     accum_ff, accum_in;
   logic [SPARSE_W-1:0]    sparse_ff, sparse_in;
   logic [COUNT_WIDTH-1:0] diff_ff, diff_in;
   logic [COUNT_WIDTH-1:0] den_ff, den_in;
   logic [2*COUNT_WIDTH-1:0] sq_ff, sq_in;
   logic [COUNT_WIDTH-1:0] rem_ff, rem_in;
   logic [DIV_STEPS-1:0]   shf_ff, shf_in;
   logic [FIT_W-1:0]       quo_ff, quo_in;
   logic [5:0]             step_ff, step_in;
   logic [FIT_W-1:0]       sum_ff, sum_in;

   logic                   rv_ff, rv_in;
   logic [CAT_W-1:0]       rw_ff, rw_in;
   logic [FIT_W-1:0]       rf_ff, rf_in;

   logic [CAT_W-1:0]       rd_addr;
   logic [COUNT_WIDTH-1:0] rd_zero, rd_one, val_zero, val_one, old_val;
   logic                   wr_zero, wr_one;
   logic [COUNT_WIDTH-1:0] wr_data;
   logic [CAT_W-1:0]       used_cats, end_lim;
   logic [COUNT_WIDTH:0]   trial;
   logic [FIT_W:0]         sum_wide;
   logic [ACCUM_W:0]       accum_wide;

   hwh_ram #(.WIDTH(COUNT_WIDTH), .DEPTH(NUM_CATS)) u_ram_zero (
      .clock  (clock),
      .wr_en  (wr_zero),
      .wr_addr(weight_ff),
      .wr_data(wr_data),
      .rd_addr(rd_addr),
      .rd_data(rd_zero)
   );

   hwh_ram #(.WIDTH(COUNT_WIDTH), .DEPTH(NUM_CATS)) u_ram_one (
      .clock  (clock),
      .wr_en  (wr_one),
      .wr_addr(weight_ff),
      .wr_data(wr_data),
      .rd_addr(rd_addr),
      .rd_data(rd_one)
   );

   assign used_cats = CAT_W'({eff_bytes(used_bytes), 3'b000}) + CAT_W'(1);
   assign end_lim   = (checked_categories > used_cats) ? used_cats : checked_categories;
   assign rd_addr   = (state_ff == ST_IDLE) ? q_head.weight : cat_ff;

   // Entries that were never written since the last clear read as zero.
   assign val_zero  = vz_rd_ff ? rd_zero : '0;
   assign val_one   = vo_rd_ff ? rd_one  : '0;
   assign old_val   = sel_ff ? val_one : val_zero;
   assign wr_data   = (&old_val) ? old_val : old_val + COUNT_WIDTH'(1);
   assign wr_zero   = (state_ff == ST_SWR) && !sel_ff;
   assign wr_one    = (state_ff == ST_SWR) && sel_ff;
   assign q_pop     = (state_ff == ST_IDLE) && q_not_empty;

   always_comb begin
      state_in    = state_ff;
      is_fit_in   = is_fit_ff;
      cat_in      = cat_ff;
      weight_in   = weight_ff;
      sel_in      = sel_ff;
      vz_in       = vz_ff;
      vo_in       = vo_ff;
      cnt_zero_in = cnt_zero_ff;
      cnt_one_in  = cnt_one_ff;
      accum_in    = accum_ff;
      sparse_in   = sparse_ff;
      diff_in     = diff_ff;
      den_in      = den_ff;
      sq_in       = sq_ff;
      rem_in      = rem_ff;
      shf_in      = shf_ff;
      quo_in      = quo_ff;
      step_in     = step_ff;
      sum_in      = sum_ff;
      rv_in       = 1'b0;
      rw_in       = rw_ff;
      rf_in       = rf_ff;
      trial       = '0;
      sum_wide    = '0;
      accum_wide  = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (q_not_empty) begin
               weight_in = q_head.weight;
               sel_in    = q_head.sel;
               cat_in    = '0;
               sum_in    = '0;
               sparse_in = '0;
               priority case (q_head.req)
                  REQ_SAMPLE: state_in = ST_SWR;
                  REQ_FITNESS: begin
                     is_fit_in = 1'b1;
                     state_in  = ST_RD;
                  end
                  REQ_END: begin
                     is_fit_in = 1'b0;
                     state_in  = (end_lim == '0) ? ST_EFIN : ST_RD;
                  end
                  default: begin
                     rv_in = 1'b1;
                     rw_in = '0;
                     rf_in = '0;
                  end
               endcase
            end
         end
         ST_SWR: begin
            if (sel_ff) begin
               vo_in[weight_ff] = 1'b1;
               cnt_one_in = (&cnt_one_ff) ? cnt_one_ff : cnt_one_ff + COUNT_WIDTH'(1);
            end else begin
               vz_in[weight_ff] = 1'b1;
               cnt_zero_in = (&cnt_zero_ff) ? cnt_zero_ff : cnt_zero_ff + COUNT_WIDTH'(1);
            end
            rv_in    = 1'b1;
            rw_in    = weight_ff;
            rf_in    = '0;
            state_in = ST_IDLE;
         end
         ST_RD: state_in = ST_LOAD;
         ST_LOAD: begin
            if (is_fit_ff) begin
               diff_in  = (val_one >= val_zero) ? val_one - val_zero : val_zero - val_one;
               den_in   = (val_zero == '0) ? COUNT_WIDTH'(1) : val_zero;
               state_in = ST_MUL;
            end else begin
               sparse_in = sparse_ff
                         + SPARSE_W'(val_zero < COUNT_WIDTH'(sparse_limit))
                         + SPARSE_W'(val_one  < COUNT_WIDTH'(sparse_limit));
               if (cat_ff + CAT_W'(1) == end_lim) begin
                  state_in = ST_EFIN;
               end else begin
                  cat_in   = cat_ff + CAT_W'(1);
                  state_in = ST_RD;
               end
            end
         end
         ST_MUL: begin
            sq_in    = diff_ff * diff_ff;
            state_in = ST_DIVI;
         end
         ST_DIVI: begin
            // A quotient at or above 2^32 saturates the whole term.
            if (sq_ff[2*COUNT_WIDTH-1:COUNT_WIDTH] >= den_ff) begin
               quo_in   = '1;
               state_in = ST_ACC;
            end else begin
               rem_in   = sq_ff[2*COUNT_WIDTH-1:COUNT_WIDTH];
               shf_in   = {sq_ff[COUNT_WIDTH-1:0], {FRAC_W{1'b0}}};
               quo_in   = '0;
               step_in  = 6'(DIV_STEPS - 1);
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            trial  = {rem_ff, shf_ff[DIV_STEPS-1]};
            shf_in = {shf_ff[DIV_STEPS-2:0], 1'b0};
            if (trial >= {1'b0, den_ff}) begin
               rem_in = COUNT_WIDTH'(trial - {1'b0, den_ff});
               quo_in = {quo_ff[FIT_W-2:0], 1'b1};
            end else begin
               rem_in = trial[COUNT_WIDTH-1:0];
               quo_in = {quo_ff[FIT_W-2:0], 1'b0};
            end
            if (step_ff == '0) begin
               state_in = ST_ACC;
            end else begin
               step_in = step_ff - 6'd1;
            end
         end
         ST_ACC: begin
            sum_wide = {1'b0, sum_ff} + {1'b0, quo_ff};
            sum_in   = sum_wide[FIT_W] ? '1 : sum_wide[FIT_W-1:0];
            if (cat_ff + CAT_W'(1) == used_cats) begin
               rv_in    = 1'b1;
               rw_in    = '0;
               rf_in    = sum_in;
               state_in = ST_IDLE;
            end else begin
               cat_in   = cat_ff + CAT_W'(1);
               state_in = ST_RD;
            end
         end
         ST_EFIN: begin
            accum_wide  = {1'b0, accum_ff} + (ACCUM_W + 1)'(sparse_ff);
            accum_in    = accum_wide[ACCUM_W] ? '1 : accum_wide[ACCUM_W-1:0];
            cnt_zero_in = '0;
            cnt_one_in  = '0;
            vz_in       = '0;
            vo_in       = '0;
            rv_in       = 1'b1;
            rw_in       = '0;
            rf_in       = '0;
            state_in    = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         vz_ff       <= '0;
         vo_ff       <= '0;
         cnt_zero_ff <= '0;
         cnt_one_ff  <= '0;
         accum_ff    <= '0;
         rv_ff       <= 1'b0;
      end else begin
         state_ff    <= state_in;
         vz_ff       <= vz_in;
         vo_ff       <= vo_in;
         cnt_zero_ff <= cnt_zero_in;
         cnt_one_ff  <= cnt_one_in;
         accum_ff    <= accum_in;
         rv_ff       <= rv_in;
      end
   end

   always_ff @(posedge clock) begin
      is_fit_ff <= is_fit_in;
      cat_ff    <= cat_in;
      weight_ff <= weight_in;
      sel_ff    <= sel_in;
      vz_rd_ff  <= vz_ff[rd_addr];
      vo_rd_ff  <= vo_ff[rd_addr];
      sparse_ff <= sparse_in;
      diff_ff   <= diff_in;
      den_ff    <= den_in;
      sq_ff     <= sq_in;
      rem_ff    <= rem_in;
      shf_ff    <= shf_in;
      quo_ff    <= quo_in;
      step_ff   <= step_in;
      sum_ff    <= sum_in;
      rw_ff     <= rw_in;
      rf_ff     <= rf_in;
   end

   assign rsp_valid                 = rv_ff;
   assign rsp_hamming_weight        = rw_ff;
   assign rsp_fitness_fixed         = rf_ff;
   assign rsp_total_zero            = cnt_zero_ff;
   assign rsp_total_one             = cnt_one_ff;
   assign rsp_under_threshold_total = accum_ff;

endmodule

[rtl/core/hwh_checker.sv]
// ---------------------------------------------------------------------------
// Histogram port checker
// Port-level properties of the histogram block, bound to the top level.
// ---------------------------------------------------------------------------
module hwh_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            busy,
   input logic                            rsp_valid,
   input logic [hwh_pkg::CAT_W-1:0]       rsp_hamming_weight,
   input logic [hwh_pkg::FIT_W-1:0]       rsp_fitness_fixed
);
   import hwh_pkg::*;

   // The queue and the result register come out of reset empty.
   assert property (@(posedge clock) $fell(reset) |-> !busy && !rsp_valid)
      else $error("busy or result strobe after reset");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_hamming_weight <= CAT_W'(DATA_W))
      else $error("weight above the word width");

   // A result carries either a sample weight or a fitness value, never both.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_hamming_weight != '0 |-> rsp_fitness_fixed == '0)
      else $error("weight and fitness both nonzero");

endmodule

bind hamming_weight_histogram_chi_square hwh_checker u_hwh_checker (
   .clock             (clock),
   .reset             (reset),
   .busy              (busy),
   .rsp_valid         (rsp_valid),
   .rsp_hamming_weight(rsp_hamming_weight),
   .rsp_fitness_fixed (rsp_fitness_fixed)
);
